/* design/repeating_timer_table_top_macros.svh */
// Assertion macros shared by the checker of the repeating timer table.
`ifndef REPEATING_TIMER_TABLE_TOP_MACROS_SVH
`define REPEATING_TIMER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rtt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_AW     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SLOT_CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int SLOT_W      = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_ADDED    = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;
  localparam logic [1:0] KIND_TICK_END = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [31:0] elapsed;
    logic [31:0] period;
    logic [31:0] repeat_limit;
    logic [31:0] user_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       fired_tag;
    logic              final_fire;
    logic              last;
  } out_item_t;

  // Request after decoding: time carries the elapsed time of a tick or the
  // period of an add, and the limit is already normalized.
  typedef struct packed {
    logic        is_tick;
    logic [31:0] time_us;
    logic [31:0] limit;
    logic [31:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [31:0] accum;
    logic [31:0] period;
    logic [31:0] limit;
    logic [31:0] fire_count;
    logic [31:0] tag;
  } slot_rec_t;

endpackage

`default_nettype wire

/* design/rtt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/rtt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtt_front import rtt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  cmd_t              cls;
  logic              push;
  logic              pop;

  // Decode the request so that the back end sees only what it uses.
  always_comb begin
    cls.is_tick = in_data.mode;
    cls.time_us = in_data.mode ? in_data.elapsed : in_data.period;
    cls.limit   = (in_data.repeat_limit == 32'd0) ? ALL_ONES32 : in_data.repeat_limit;
    cls.tag     = in_data.user_tag;
  end

  assign in_ready  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

/* design/rtt_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtt_back import rtt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [TIMER_SLOTS-1:0] live_r, live_nxt;
  logic [SLOT_CNT_W-1:0] idx_r, idx_nxt;
  logic                  b_vld_r, b_vld_nxt;
  logic [SLOT_AW-1:0]    b_idx_r, b_idx_nxt;
  logic [31:0]           elapsed_r, elapsed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  we;
  logic [SLOT_AW-1:0]    waddr;
  slot_rec_t             wdata;
  logic                  re;
  slot_rec_t             rdata;

  logic                  out_free;
  logic                  free_found;
  logic [SLOT_AW-1:0]    free_idx;
  logic [32:0]           sum_wide;
  logic [31:0]           sum;
  logic [31:0]           cnt_inc;
  logic                  fire;
  logic                  fin;
  logic                  b_live;
  logic                  stall;
  slot_rec_t             upd;

  rtt_ram #(
    .WIDTH($bits(slot_rec_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(idx_r[SLOT_AW-1:0]),
    .rdata(rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Lowest free slot for an add.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_AW'(i);
      end
    end
  end

  // Update of the slot whose record was last read out of the RAM.
  always_comb begin
    sum_wide = {1'b0, rdata.accum} + {1'b0, elapsed_r};
    sum      = sum_wide[32] ? ALL_ONES32 : sum_wide[31:0];
    fire     = (sum >= rdata.period);
    cnt_inc  = rdata.fire_count + 32'd1;
    fin      = (cnt_inc == rdata.limit);
    upd      = rdata;
    upd.accum      = fire ? 32'd0 : sum;
    upd.fire_count = fire ? cnt_inc : rdata.fire_count;
    b_live   = live_r[b_idx_r];
    stall    = b_vld_r && b_live && fire && !out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    idx_nxt       = idx_r;
    b_vld_nxt     = b_vld_r;
    b_idx_nxt     = b_idx_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = b_idx_r;
    wdata         = upd;
    re            = 1'b0;
    cmd_pop       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_tick) begin
            cmd_pop     = 1'b1;
            elapsed_nxt = cmd.time_us;
            idx_nxt     = '0;
            b_vld_nxt   = 1'b0;
            state_nxt   = ST_WALK;
          end else if (out_free) begin
            cmd_pop                 = 1'b1;
            out_valid_nxt           = 1'b1;
            out_data_nxt.fired_tag  = '0;
            out_data_nxt.final_fire = 1'b0;
            out_data_nxt.last       = 1'b1;
            if (free_found) begin
              live_nxt[free_idx]     = 1'b1;
              we                     = 1'b1;
              waddr                  = free_idx;
              wdata.accum            = '0;
              wdata.period           = cmd.time_us;
              wdata.limit            = cmd.limit;
              wdata.fire_count       = '0;
              wdata.tag              = cmd.tag;
              out_data_nxt.kind      = KIND_ADDED;
              out_data_nxt.slot      = SLOT_W'(free_idx);
            end else begin
              out_data_nxt.kind      = KIND_FULL;
              out_data_nxt.slot      = '0;
            end
          end
        end
      end

      ST_WALK: begin
        if (!stall) begin
          if (b_vld_r && b_live) begin
            we = 1'b1;
            if (fire) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.kind       = KIND_FIRED;
              out_data_nxt.slot       = SLOT_W'(b_idx_r);
              out_data_nxt.fired_tag  = rdata.tag;
              out_data_nxt.final_fire = fin;
              out_data_nxt.last       = 1'b0;
              if (fin) begin
                live_nxt[b_idx_r] = 1'b0;
              end
            end
          end
          // Read of the next slot overlaps the update of the current one.
          if (idx_r < SLOT_CNT_W'(TIMER_SLOTS)) begin
            re        = 1'b1;
            b_vld_nxt = 1'b1;
            b_idx_nxt = idx_r[SLOT_AW-1:0];
            idx_nxt   = idx_r + 1'b1;
          end else begin
            b_vld_nxt = 1'b0;
            state_nxt = ST_END;
          end
        end
      end

      ST_END: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = KIND_TICK_END;
          out_data_nxt.slot       = '0;
          out_data_nxt.fired_tag  = '0;
          out_data_nxt.final_fire = 1'b0;
          out_data_nxt.last       = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      b_vld_r     <= b_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    b_idx_r    <= b_idx_nxt;
    elapsed_r  <= elapsed_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* design/repeating_timer_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Table of TIMER_SLOTS repeating timers. An add request takes the lowest
// free slot and answers with that slot, or with a full result when no slot
// is free. A tick request walks every slot in order through the single read
// port of the slot RAM, one slot per cycle except while a fire result waits
// on a stalled result channel; it gives one fire result per timer that
// expired and always ends with a tick-end result. A two-entry request queue
// lets requests be taken while a tick is still walking. Slot records need no
// clearing after reset, so the block is ready as soon as reset is released.
module repeating_timer_table_top import rtt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  rtt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  rtt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* design/rtt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "repeating_timer_table_top_macros.svh"

module rtt_checker import rtt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A request that waits must hold still.
  `RTT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
    in_valid && $stable(in_data), "request changed while waiting")

  // A result that is not taken must stay put.
  `RTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "result changed while stalled")

  // Only fire results leave the request unfinished.
  `RTT_ASSERT_NOW(a_last_kind, clk, rst_n, out_valid,
    out_data.last == (out_data.kind != KIND_FIRED), "last flag does not match kind")

  // The final-fire flag belongs to fire results alone.
  `RTT_ASSERT_NOW(a_final_kind, clk, rst_n, out_valid && out_data.final_fire,
    out_data.kind == KIND_FIRED, "final fire on a result that is not a fire")

  // Full and tick-end results carry no slot and no tag.
  `RTT_ASSERT_NOW(a_empty_fields, clk, rst_n,
    out_valid && (out_data.kind == KIND_FULL || out_data.kind == KIND_TICK_END),
    out_data.slot == '0 && out_data.fired_tag == '0, "stray slot or tag")

endmodule

bind repeating_timer_table_top rtt_checker u_rtt_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rtt_pkg::*;

  localparam logic MODE_ADD     = 1'b0;
  localparam logic MODE_TICK    = 1'b1;
  localparam int   RANDOM_ITEMS = 360;
  localparam int   STALL_LIMIT  = 3000;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   DRAIN_CYCLES = 40;

  localparam int MIX_FILL = 0;
  localparam int MIX_TICK = 1;
  localparam int MIX_EVEN = 2;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Hand-typed expectation that travels with the request on the wire.
  bit        in_typed;
  out_item_t in_typed_result;

  bit          live_q [TIMER_SLOTS];
  logic [31:0] accum_q [TIMER_SLOTS];
  logic [31:0] period_q [TIMER_SLOTS];
  logic [31:0] limit_q [TIMER_SLOTS];
  logic [31:0] count_q [TIMER_SLOTS];
  logic [31:0] tag_q [TIMER_SLOTS];

  out_item_t timer_events_due[$];
  stim_row_t directed_rows[$];

  int error_count;
  int results_seen;
  int burst_left;
  int adds_placed;
  int adds_rejected;
  int ticks_taken;
  int firings;
  int final_firings;
  bit hold_request;

  repeating_timer_table_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer table as the block should see it; queues every result a request causes.
  task automatic advance_timer_table(input in_item_t r);
    out_item_t   ev;
    logic [31:0] sum;
    bit          placed;
    ev = '0;
    placed = 1'b0;
    if (r.mode == MODE_ADD) begin
      for (int i = 0; i < TIMER_SLOTS && !placed; i++) begin
        if (!live_q[i]) begin
          live_q[i]   = 1'b1;
          accum_q[i]  = '0;
          period_q[i] = r.period;
          limit_q[i]  = (r.repeat_limit == '0) ? ALL_ONES32 : r.repeat_limit;
          count_q[i]  = '0;
          tag_q[i]    = r.user_tag;
          ev.slot     = SLOT_W'(i);
          placed      = 1'b1;
        end
      end
      if (placed) begin
        ev.kind = KIND_ADDED;
        adds_placed++;
      end else begin
        ev.kind = KIND_FULL;
        adds_rejected++;
      end
      ev.last = 1'b1;
      timer_events_due = {timer_events_due, ev};
    end else begin
      ticks_taken++;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (live_q[i]) begin
          sum = accum_q[i] + r.elapsed;
          if (sum < r.elapsed) sum = ALL_ONES32;
          accum_q[i] = sum;
          if (sum >= period_q[i]) begin
            accum_q[i] = '0;
            count_q[i] = count_q[i] + 32'd1;
            ev = '0;
            ev.kind = KIND_FIRED;
            ev.slot = SLOT_W'(i);
            ev.fired_tag = tag_q[i];
            ev.final_fire = (count_q[i] == limit_q[i]);
            if (ev.final_fire) begin
              live_q[i] = 1'b0;
              final_firings++;
            end
            firings++;
            timer_events_due = {timer_events_due, ev};
          end
        end
      end
      ev = '0;
      ev.kind = KIND_TICK_END;
      ev.last = 1'b1;
      timer_events_due = {timer_events_due, ev};
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    int        n;
    out_item_t due;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n = timer_events_due.size();
        advance_timer_table(in_data);
        // Typed rows cause exactly one result, so it replaces the predicted one.
        if (in_typed) timer_events_due[n] = in_typed_result;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (timer_events_due.size() == 0) begin
          $display("%0t: result with nothing awaited, actual %p", $time, out_data);
          error_count++;
        end else begin
          due = timer_events_due.pop_front();
          check_field("kind", 32'(due.kind), 32'(out_data.kind));
          check_field("slot", 32'(due.slot), 32'(out_data.slot));
          check_field("fired_tag", due.fired_tag, out_data.fired_tag);
          check_field("final_fire", 32'(due.final_fire), 32'(out_data.final_fire));
          check_field("last", 32'(due.last), 32'(out_data.last));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int style;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      style = $urandom_range(0, 3);
      for (int step = 0; step < 24; step++) begin
        @(negedge clk);
        if (hold_request && !hold_done) begin
          hold_done = 1'b1;
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (style)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = (step % 4 != 3);
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: pick_period = '0;
      1: pick_period = ALL_ONES32;
      2: pick_period = $urandom();
      default: pick_period = $urandom_range(1, 60);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 15))
      0: pick_limit = '0;
      1: pick_limit = ($urandom_range(0, 1)) ? ALL_ONES32 : $urandom();
      default: pick_limit = $urandom_range(1, 4);
    endcase
  endfunction

  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(0, 14))
      0: pick_elapsed = '0;
      1: pick_elapsed = ALL_ONES32;
      2: pick_elapsed = $urandom();
      default: pick_elapsed = $urandom_range(0, 40);
    endcase
  endfunction

  // Fields that the request kind ignores carry random noise.
  function automatic in_item_t add_request(input logic [31:0] period,
                                           input logic [31:0] limit,
                                           input logic [31:0] tag);
    add_request.mode = MODE_ADD;
    add_request.elapsed = $urandom();
    add_request.period = period;
    add_request.repeat_limit = limit;
    add_request.user_tag = tag;
  endfunction

  function automatic in_item_t tick_request(input logic [31:0] elapsed);
    tick_request.mode = MODE_TICK;
    tick_request.elapsed = elapsed;
    tick_request.period = $urandom();
    tick_request.repeat_limit = $urandom();
    tick_request.user_tag = $urandom();
  endfunction

  function automatic out_item_t single_result(input logic [1:0] kind, input int slot);
    single_result = '0;
    single_result.kind = kind;
    single_result.slot = SLOT_W'(slot);
    single_result.last = 1'b1;
  endfunction

  function automatic stim_row_t row(input in_item_t r, input bit typed,
                                    input out_item_t res);
    row.req = r;
    row.typed = typed;
    row.res = res;
  endfunction

  task automatic offer_request(input in_item_t r, input bit typed, input out_item_t res);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = r;
    in_typed = typed;
    in_typed_result = res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic await_all_results();
    in_valid = 1'b0;
    burst_left = 0;
    while (timer_events_due.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int        sent;
    int        phase;
    int        mix;
    int        count;
    int        add_odds;
    in_item_t  r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_typed = 1'b0;
    in_typed_result = '0;
    hold_request = 1'b0;
    burst_left = 0;

    // Empty table first, then the extremes of period, limit and elapsed time.
    directed_rows = {
      row(tick_request('0), 1, single_result(KIND_TICK_END, 0)),
      row(tick_request(ALL_ONES32), 1, single_result(KIND_TICK_END, 0)),
      row(add_request('0, '0, ALL_ONES32), 1, single_result(KIND_ADDED, 0)),
      row(add_request(ALL_ONES32, 32'd1, '0), 1, single_result(KIND_ADDED, 1)),
      row(add_request(32'd5, 32'd2, 32'hA5A5_A5A5), 1, single_result(KIND_ADDED, 2)),
      row(add_request(32'hFFFF_FFFE, ALL_ONES32, 32'h5A5A_5A5A), 1,
          single_result(KIND_ADDED, 3)),
      row(add_request(32'd3, '0, 32'h1234_5678), 1, single_result(KIND_ADDED, 4)),
      row(tick_request(32'd3), 0, '0),
      row(tick_request('0), 0, '0),
      row(tick_request(ALL_ONES32), 0, '0),
      row(tick_request(32'd5), 0, '0),
      // Slot 1 was freed by its final firing, so it is the lowest free one again.
      row(add_request(32'd1000, 32'd3, 32'hDEAD_0001), 1, single_result(KIND_ADDED, 1)),
      row(tick_request(32'd999), 0, '0),
      row(tick_request(32'd1), 0, '0),
      row(tick_request(32'h7FFF_FFFF), 0, '0),
      row(tick_request(32'h8000_0001), 0, '0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k])
      offer_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);
    await_all_results();

    // The first phase fills the table; the third runs while the results are held off.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) mix = MIX_FILL;
      else if (phase == 2) mix = MIX_TICK;
      else mix = $urandom_range(0, 2);
      if (phase == 2) hold_request = 1'b1;
      case (mix)
        MIX_FILL: add_odds = 90;
        MIX_TICK: add_odds = 15;
        default:  add_odds = 50;
      endcase
      count = (mix == MIX_FILL) ? $urandom_range(34, 40) : $urandom_range(15, 40);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(1, 100) <= add_odds)
          r = add_request(pick_period(), pick_limit(), $urandom());
        else
          r = tick_request(pick_elapsed());
        offer_request(r, 1'b0, '0);
        sent++;
      end
      if (phase == 1 || $urandom_range(0, 2) == 0) await_all_results();
      phase++;
    end

    await_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d timers added, %0d adds rejected on a full table, %0d ticks,",
             adds_placed, adds_rejected, ticks_taken);
    $display("%0d firings of which %0d were final, %0d results checked.",
             firings, final_firings, results_seen);
    if (error_count == 0 && timer_events_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
